FILE: src/csrb_pkg.sv
// Shared constants, types and codes for the circular source region blanker.
package csrb_pkg;

  // Image and source limits
  localparam int MAX_WIDTH   = 256;
  localparam int MAX_HEIGHT  = 256;
  localparam int MAX_RADIUS  = 31;
  localparam int MAX_SOURCES = 1024;

  localparam int NPIX   = MAX_WIDTH * MAX_HEIGHT;
  localparam int ADDR_W = $clog2(NPIX);
  localparam int X_W    = $clog2(MAX_WIDTH);
  localparam int Y_W    = $clog2(MAX_HEIGHT);
  localparam int RAD_W  = $clog2(MAX_RADIUS + 1);
  localparam int SQ_W   = 2 * RAD_W + 1;

  // Field widths
  localparam int REQ_W     = 2;
  localparam int POS_W     = 10;
  localparam int IDX_W     = 10;
  localparam int LABEL_W   = 11;
  localparam int CNT_W     = 12;
  localparam int TOTAL_W   = 17;
  localparam int RADIUS_W  = 5;
  localparam int SIZE_W    = 9;
  localparam int C_W       = POS_W + 2;
  localparam int ENTRY_W   = LABEL_W + 2;

  localparam logic [LABEL_W-1:0] LABEL_NONE = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = '1;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_RADIUS = 2'd0;
  localparam logic [1:0] REG_REJECT = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_LOAD   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SOURCE = 2'd1;
  localparam logic [REQ_W-1:0] REQ_READ   = 2'd2;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    logic                reject;
    logic [SIZE_W-1:0]   width;
    logic [SIZE_W-1:0]   height;
  } csrb_cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CHECK,
    ST_CHECK_DRAIN,
    ST_BLANK,
    ST_BLANK_DRAIN,
    ST_DONE
  } csrb_state_e;

endpackage

FILE: src/csrb_req_if.sv
// Request channel: valid/ready handshake with the input item fields.
interface csrb_req_if;
  logic                             valid;
  logic                             ready;
  logic [csrb_pkg::REQ_W-1:0]       req_type;
  logic signed [csrb_pkg::POS_W-1:0] pos_x;
  logic signed [csrb_pkg::POS_W-1:0] pos_y;
  logic                             detect_bit_in;
  logic                             background_bit_in;
  logic [csrb_pkg::IDX_W-1:0]       source_index;
  logic                             source_ok;

  modport source (
    output valid, req_type, pos_x, pos_y, detect_bit_in, background_bit_in,
           source_index, source_ok,
    input  ready
  );
  modport sink (
    input  valid, req_type, pos_x, pos_y, detect_bit_in, background_bit_in,
           source_index, source_ok,
    output ready
  );
endinterface

FILE: src/csrb_res_if.sv
// Result channel: valid/ready handshake with the result item fields.
interface csrb_res_if;
  logic                                valid;
  logic                                ready;
  logic                                status_ok_out;
  logic [csrb_pkg::CNT_W-1:0]          newly_found;
  logic [csrb_pkg::CNT_W-1:0]          blocked_pixels;
  logic signed [csrb_pkg::LABEL_W-1:0] label_out;
  logic                                background_bit_out;
  logic                                detect_bit_out;
  logic [csrb_pkg::TOTAL_W-1:0]        total_found;

  modport source (
    output valid, status_ok_out, newly_found, blocked_pixels, label_out,
           background_bit_out, detect_bit_out, total_found,
    input  ready
  );
  modport sink (
    input  valid, status_ok_out, newly_found, blocked_pixels, label_out,
           background_bit_out, detect_bit_out, total_found,
    output ready
  );
endinterface

FILE: src/circular_source_region_blanker_core.sv
// Top level of the circular source region blanker: sequencer over the pixel RAM.
//
// Usage: items arrive on req_i (valid/ready), one result beat per item leaves on
// res_o. The user must write registers over the APB-style port only while the
// block is idle; the block does not enforce this. Load items write a pixel's
// mask bits and clear its label; read items return a pixel; source items blank
// the clipped circle around a centre.
// A source item blanks its clipped window of at most (2R+1)^2 pixels in one
// pass, preceded by a detection-mask pass when border rejection runs one.
// The pixel RAM has a single read port; each pass scans one pixel per cycle,
// and the blanking pass reads a pixel while the previous one is written back.
// One item is worked on at a time. The result sits in an output register, so
// while the receiver stalls the block takes and processes one more item and
// holds its result until that register frees.
// Reset clears the state machine, the output valid flag and the running found
// count. The pixel maps are not cleared: a pixel is undefined until loaded.
module circular_source_region_blanker_core (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csrb_pkg::PADDR_W-1:0]  paddr,
  input  logic [csrb_pkg::PDATA_W-1:0]  pwdata,
  output logic [csrb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  csrb_req_if.sink                      req_i,
  csrb_res_if.source                    res_o
);

  localparam int C_W     = csrb_pkg::C_W;
  localparam int X_W     = csrb_pkg::X_W;
  localparam int Y_W     = csrb_pkg::Y_W;
  localparam int RAD_W   = csrb_pkg::RAD_W;
  localparam int SQ_W    = csrb_pkg::SQ_W;
  localparam int ADDR_W  = csrb_pkg::ADDR_W;
  localparam int LABEL_W = csrb_pkg::LABEL_W;
  localparam int ENTRY_W = csrb_pkg::ENTRY_W;
  localparam int CNT_W   = csrb_pkg::CNT_W;
  localparam int TOTAL_W = csrb_pkg::TOTAL_W;
  localparam int SIZE_W  = csrb_pkg::SIZE_W;
  localparam int POS_W   = csrb_pkg::POS_W;
  localparam int IDX_W   = csrb_pkg::IDX_W;

  csrb_pkg::csrb_cfg_t   cfg;
  csrb_pkg::csrb_state_e state_q, state_d;

  // Configuration registers
  csrb_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Effective sizes and radius (saturated)
  logic [SIZE_W-1:0]         w_eff, h_eff;
  logic [csrb_pkg::RADIUS_W-1:0] r_sat;
  logic [RAD_W-1:0]          r_eff;
  logic [SQ_W-1:0]           r2;

  assign w_eff = (cfg.width > SIZE_W'(csrb_pkg::MAX_WIDTH)) ?
                 SIZE_W'(csrb_pkg::MAX_WIDTH) : cfg.width;
  assign h_eff = (cfg.height > SIZE_W'(csrb_pkg::MAX_HEIGHT)) ?
                 SIZE_W'(csrb_pkg::MAX_HEIGHT) : cfg.height;
  assign r_sat = (cfg.radius > csrb_pkg::RADIUS_W'(csrb_pkg::MAX_RADIUS)) ?
                 csrb_pkg::RADIUS_W'(csrb_pkg::MAX_RADIUS) : cfg.radius;
  assign r_eff = RAD_W'(r_sat);
  assign r2    = SQ_W'(SQ_W'(r_eff) * SQ_W'(r_eff));

  // Decode of the incoming item: bounds, window and clipping
  logic signed [C_W-1:0] px_s, py_s, r_c, w_c, h_c, wm1, hm1;
  logic signed [C_W-1:0] x0, x1, y0, y1, x0c, x1c, y0c, y1c;
  logic                  edge_hit, win_empty, pix_in, idx_ok, ok_pre;
  logic [ADDR_W-1:0]     pix_addr;

  always_comb begin
    px_s = $signed({{(C_W-POS_W){req_i.pos_x[POS_W-1]}}, req_i.pos_x});
    py_s = $signed({{(C_W-POS_W){req_i.pos_y[POS_W-1]}}, req_i.pos_y});
    r_c  = $signed({{(C_W-RAD_W){1'b0}}, r_eff});
    w_c  = $signed({{(C_W-SIZE_W){1'b0}}, w_eff});
    h_c  = $signed({{(C_W-SIZE_W){1'b0}}, h_eff});
    wm1  = w_c - $signed(C_W'(1));
    hm1  = h_c - $signed(C_W'(1));
    x0   = px_s - r_c;
    x1   = px_s + r_c;
    y0   = py_s - r_c;
    y1   = py_s + r_c;
    edge_hit  = (x0 < 0) || (x1 >= w_c) || (y0 < 0) || (y1 >= h_c);
    x0c  = (x0 < 0) ? '0 : x0;
    y0c  = (y0 < 0) ? '0 : y0;
    x1c  = (x1 > wm1) ? wm1 : x1;
    y1c  = (y1 > hm1) ? hm1 : y1;
    win_empty = (x0c > x1c) || (y0c > y1c);
    pix_in    = (px_s >= 0) && (px_s < w_c) && (py_s >= 0) && (py_s < h_c);
    idx_ok    = 32'(req_i.source_index) < csrb_pkg::MAX_SOURCES;
    ok_pre    = req_i.source_ok && !(cfg.reject && edge_hit);
    pix_addr  = ADDR_W'(ADDR_W'(py_s[Y_W-1:0]) * ADDR_W'(csrb_pkg::MAX_WIDTH))
              + ADDR_W'(px_s[X_W-1:0]);
  end

  // Item state
  logic signed [C_W-1:0] px_q, py_q;
  logic [X_W-1:0]        x0_q, x1_q, cx_q;
  logic [Y_W-1:0]        y0_q, y1_q, cy_q;
  logic [IDX_W-1:0]      idx_q;
  logic                  ok_q;
  logic [CNT_W-1:0]      found_q, blocked_q;
  logic [LABEL_W-1:0]    lab_q;
  logic                  bg_q, det_q;
  logic [TOTAL_W-1:0]    total_q;

  // Scan stage: one window pixel per cycle
  logic signed [C_W-1:0] dx, dy, adx_f, ady_f;
  logic [RAD_W-1:0]      adx, ady;
  logic [SQ_W-1:0]       dsum;
  logic                  in_circ, scan_last;
  logic [ADDR_W-1:0]     scan_addr;

  always_comb begin
    dx    = $signed({{(C_W-X_W){1'b0}}, cx_q}) - px_q;
    dy    = $signed({{(C_W-Y_W){1'b0}}, cy_q}) - py_q;
    adx_f = dx[C_W-1] ? -dx : dx;
    ady_f = dy[C_W-1] ? -dy : dy;
    adx   = adx_f[RAD_W-1:0];
    ady   = ady_f[RAD_W-1:0];
    dsum  = SQ_W'(SQ_W'(adx) * SQ_W'(adx)) + SQ_W'(SQ_W'(ady) * SQ_W'(ady));
    in_circ   = dsum <= r2;
    scan_last = (cx_q == x1_q) && (cy_q == y1_q);
    scan_addr = ADDR_W'(ADDR_W'(cy_q) * ADDR_W'(csrb_pkg::MAX_WIDTH)) + ADDR_W'(cx_q);
  end

  // Read-data stage: pixel read in the previous cycle
  logic                p_valid_q, p_in_q;
  logic [ADDR_W-1:0]   p_addr_q;
  logic [ENTRY_W-1:0]  ram_rdata;
  logic [LABEL_W-1:0]  rd_label;
  logic                rd_bg, rd_det;
  logic                blank_hit, check_fail;

  assign rd_label   = ram_rdata[ENTRY_W-1:2];
  assign rd_bg      = ram_rdata[1];
  assign rd_det     = ram_rdata[0];
  assign blank_hit  = p_valid_q && p_in_q && (rd_label == csrb_pkg::LABEL_NONE);
  assign check_fail = p_valid_q && p_in_q && !rd_det;

  // Output register
  logic out_valid_q, out_free;
  assign out_free = !out_valid_q || res_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      csrb_pkg::ST_IDLE: begin
        if (req_i.valid) begin
          case (req_i.req_type)
            csrb_pkg::REQ_LOAD: state_d = csrb_pkg::ST_DONE;
            csrb_pkg::REQ_READ: state_d = pix_in ? csrb_pkg::ST_READ : csrb_pkg::ST_DONE;
            csrb_pkg::REQ_SOURCE: begin
              if (!idx_ok || win_empty) begin
                state_d = csrb_pkg::ST_DONE;
              end else if (cfg.reject && ok_pre) begin
                state_d = csrb_pkg::ST_CHECK;
              end else begin
                state_d = csrb_pkg::ST_BLANK;
              end
            end
            default: state_d = csrb_pkg::ST_DONE;
          endcase
        end
      end
      csrb_pkg::ST_READ:        state_d = csrb_pkg::ST_DONE;
      csrb_pkg::ST_CHECK:
        state_d = scan_last ? csrb_pkg::ST_CHECK_DRAIN : csrb_pkg::ST_CHECK;
      csrb_pkg::ST_CHECK_DRAIN: state_d = csrb_pkg::ST_BLANK;
      csrb_pkg::ST_BLANK:
        state_d = scan_last ? csrb_pkg::ST_BLANK_DRAIN : csrb_pkg::ST_BLANK;
      csrb_pkg::ST_BLANK_DRAIN: state_d = csrb_pkg::ST_DONE;
      csrb_pkg::ST_DONE:        state_d = out_free ? csrb_pkg::ST_IDLE : csrb_pkg::ST_DONE;
      default:                  state_d = csrb_pkg::ST_IDLE;
    endcase
  end

  // Control outputs: handshake and RAM ports
  logic               in_acc, scanning, blank_wb;
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata;

  always_comb begin
    req_i.ready = 1'b0;
    scanning    = 1'b0;
    blank_wb    = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    ram_waddr   = p_addr_q;
    ram_raddr   = scan_addr;
    ram_wdata   = {(ok_q ? LABEL_W'(idx_q) : rd_label), 1'b0, rd_det};
    unique case (state_q)
      csrb_pkg::ST_IDLE: begin
        req_i.ready = 1'b1;
        ram_waddr   = pix_addr;
        ram_raddr   = pix_addr;
        ram_wdata   = {csrb_pkg::LABEL_NONE, req_i.background_bit_in,
                       req_i.detect_bit_in};
        ram_we = req_i.valid && (req_i.req_type == csrb_pkg::REQ_LOAD) && pix_in;
        ram_re = req_i.valid && (req_i.req_type == csrb_pkg::REQ_READ) && pix_in;
      end
      csrb_pkg::ST_CHECK: begin
        scanning = 1'b1;
        ram_re   = 1'b1;
      end
      csrb_pkg::ST_BLANK: begin
        scanning = 1'b1;
        ram_re   = 1'b1;
        blank_wb = 1'b1;
        ram_we   = blank_hit;
      end
      csrb_pkg::ST_BLANK_DRAIN: begin
        blank_wb = 1'b1;
        ram_we   = blank_hit;
      end
      default: ;
    endcase
  end

  assign in_acc = req_i.valid && req_i.ready;

  // Pixel RAM: {label, background bit, detection bit}
  csrb_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (csrb_pkg::NPIX)
  ) u_pix_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= csrb_pkg::ST_IDLE;
      p_valid_q   <= 1'b0;
      out_valid_q <= 1'b0;
      total_q     <= '0;
    end else begin
      state_q   <= state_d;
      p_valid_q <= scanning;
      if (blank_wb && blank_hit && ok_q && (total_q != csrb_pkg::TOTAL_MAX)) begin
        total_q <= total_q + TOTAL_W'(1);
      end
      if (state_q == csrb_pkg::ST_DONE && out_free) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Item and scan registers
  always_ff @(posedge clk_i) begin
    p_in_q   <= in_circ;
    p_addr_q <= scan_addr;
    if (in_acc) begin
      px_q      <= px_s;
      py_q      <= py_s;
      x0_q      <= x0c[X_W-1:0];
      x1_q      <= x1c[X_W-1:0];
      y0_q      <= y0c[Y_W-1:0];
      y1_q      <= y1c[Y_W-1:0];
      cx_q      <= x0c[X_W-1:0];
      cy_q      <= y0c[Y_W-1:0];
      idx_q     <= req_i.source_index;
      ok_q      <= (req_i.req_type == csrb_pkg::REQ_SOURCE) && idx_ok && ok_pre;
      found_q   <= '0;
      blocked_q <= '0;
      lab_q     <= csrb_pkg::LABEL_NONE;
      bg_q      <= 1'b0;
      det_q     <= 1'b0;
    end
    if (state_q == csrb_pkg::ST_READ) begin
      lab_q <= rd_label;
      bg_q  <= rd_bg;
      det_q <= rd_det;
    end
    // Raster walk over the clipped window
    if (scanning) begin
      if (cx_q == x1_q) begin
        cx_q <= x0_q;
        cy_q <= cy_q + Y_W'(1);
      end else begin
        cx_q <= cx_q + X_W'(1);
      end
    end
    if (state_q == csrb_pkg::ST_CHECK_DRAIN) begin
      cx_q <= x0_q;
      cy_q <= y0_q;
    end
    // Detection-mask pass drops the ok flag
    if ((state_q == csrb_pkg::ST_CHECK || state_q == csrb_pkg::ST_CHECK_DRAIN) &&
        check_fail) begin
      ok_q <= 1'b0;
    end
    // Blanking pass counts unlabelled pixels
    if (blank_wb && blank_hit) begin
      if (ok_q) begin
        found_q <= found_q + CNT_W'(1);
      end else begin
        blocked_q <= blocked_q + CNT_W'(1);
      end
    end
    // Result beat
    if (state_q == csrb_pkg::ST_DONE && out_free) begin
      res_o.status_ok_out      <= ok_q;
      res_o.newly_found        <= found_q;
      res_o.blocked_pixels     <= blocked_q;
      res_o.label_out          <= $signed(lab_q);
      res_o.background_bit_out <= bg_q;
      res_o.detect_bit_out     <= det_q;
      res_o.total_found        <= total_q;
    end
  end

  assign res_o.valid = out_valid_q;

  // Assertions
  a_no_rw_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re && (ram_waddr == ram_raddr)))
    else $error("pixel RAM read and write hit the same entry");

  a_found_needs_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && (res_o.newly_found != '0)) |-> res_o.status_ok_out)
    else $error("found pixels reported for a bad source");

  a_found_xor_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> ((res_o.newly_found == '0) || (res_o.blocked_pixels == '0)))
    else $error("source reports both found and blocked pixels");

  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (total_q >= $past(total_q)))
    else $error("running found count decreased");

endmodule

FILE: src/csrb_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module csrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

FILE: src/csrb_cfg.sv
// APB-style configuration registers of the blanker.
module csrb_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [csrb_pkg::PADDR_W-1:0]  paddr,
  input  logic [csrb_pkg::PDATA_W-1:0]  pwdata,
  output logic [csrb_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output csrb_pkg::csrb_cfg_t           cfg_o
);

  csrb_pkg::csrb_cfg_t cfg_q;
  logic [1:0]          reg_idx;
  logic                wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg_o   = cfg_q;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radius <= '0;
      cfg_q.reject <= 1'b0;
      cfg_q.width  <= csrb_pkg::SIZE_W'(csrb_pkg::MAX_WIDTH);
      cfg_q.height <= csrb_pkg::SIZE_W'(csrb_pkg::MAX_HEIGHT);
    end else if (wr_en) begin
      unique case (reg_idx)
        csrb_pkg::REG_RADIUS: cfg_q.radius <= pwdata[csrb_pkg::RADIUS_W-1:0];
        csrb_pkg::REG_REJECT: cfg_q.reject <= pwdata[0];
        csrb_pkg::REG_WIDTH:  cfg_q.width  <= pwdata[csrb_pkg::SIZE_W-1:0];
        csrb_pkg::REG_HEIGHT: cfg_q.height <= pwdata[csrb_pkg::SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // Read decode
  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      csrb_pkg::REG_RADIUS: prdata = csrb_pkg::PDATA_W'(cfg_q.radius);
      csrb_pkg::REG_REJECT: prdata = csrb_pkg::PDATA_W'(cfg_q.reject);
      csrb_pkg::REG_WIDTH:  prdata = csrb_pkg::PDATA_W'(cfg_q.width);
      csrb_pkg::REG_HEIGHT: prdata = csrb_pkg::PDATA_W'(cfg_q.height);
      default:              prdata = '0;
    endcase
  end

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the circular source region blanker core.
`timescale 1ns / 1ps

module tb_top;

  localparam int REQ_W       = csrb_pkg::REQ_W;
  localparam int POS_W       = csrb_pkg::POS_W;
  localparam int IDX_W       = csrb_pkg::IDX_W;
  localparam int CNT_W       = csrb_pkg::CNT_W;
  localparam int LABEL_W     = csrb_pkg::LABEL_W;
  localparam int TOTAL_W     = csrb_pkg::TOTAL_W;
  localparam int PADDR_W     = csrb_pkg::PADDR_W;
  localparam int PDATA_W     = csrb_pkg::PDATA_W;
  localparam int NPIX        = csrb_pkg::NPIX;
  localparam int MAX_WIDTH   = csrb_pkg::MAX_WIDTH;
  localparam int MAX_HEIGHT  = csrb_pkg::MAX_HEIGHT;
  localparam int MAX_RADIUS  = csrb_pkg::MAX_RADIUS;
  localparam int MAX_SOURCES = csrb_pkg::MAX_SOURCES;
  localparam int RADIUS_W    = csrb_pkg::RADIUS_W;
  localparam int SIZE_W      = csrb_pkg::SIZE_W;

  localparam logic [LABEL_W-1:0] LABEL_NONE = csrb_pkg::LABEL_NONE;
  localparam logic [TOTAL_W-1:0] TOTAL_MAX  = csrb_pkg::TOTAL_MAX;

  localparam logic [REQ_W-1:0] REQ_LOAD   = csrb_pkg::REQ_LOAD;
  localparam logic [REQ_W-1:0] REQ_SOURCE = csrb_pkg::REQ_SOURCE;
  localparam logic [REQ_W-1:0] REQ_READ   = csrb_pkg::REQ_READ;

  localparam logic [1:0] REG_RADIUS = csrb_pkg::REG_RADIUS;
  localparam logic [1:0] REG_REJECT = csrb_pkg::REG_REJECT;
  localparam logic [1:0] REG_WIDTH  = csrb_pkg::REG_WIDTH;
  localparam logic [1:0] REG_HEIGHT = csrb_pkg::REG_HEIGHT;

  localparam int WATCHDOG_LIMIT = 40000;
  localparam int SETTLE_CYCLES  = 8;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [REQ_W-1:0]        kind;
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    det;
    logic                    bg;
    logic [IDX_W-1:0]        idx;
    logic                    ok;
  } pix_req_t;

  typedef struct {
    logic                      ok;
    logic [CNT_W-1:0]          found;
    logic [CNT_W-1:0]          blocked;
    logic signed [LABEL_W-1:0] label;
    logic                      bg;
    logic                      det;
    logic [TOTAL_W-1:0]        total;
  } pix_res_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  csrb_req_if req_if ();
  csrb_res_if res_if ();

  circular_source_region_blanker_core i_dut (
    .clk_i,
    .rst_ni,
    .psel,
    .penable,
    .pwrite,
    .paddr,
    .pwdata,
    .prdata,
    .pready,
    .req_i (req_if),
    .res_o (res_if)
  );

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Shadow of the pixel maps, the running count and the registers
  logic [LABEL_W-1:0]  label_map  [NPIX];
  bit                  bg_map     [NPIX];
  bit                  det_map    [NPIX];
  bit                  loaded_map [NPIX];
  logic [TOTAL_W-1:0]  found_total = '0;
  csrb_pkg::csrb_cfg_t cfg_shadow;

  pix_res_t pixel_reply_q [$];
  int       fails = 0;
  int       idle_run = 0;
  bit       tx_idle_en = 1'b1;
  bit       rx_idle_en = 1'b1;

  function automatic int eff_width();
    return (cfg_shadow.width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_shadow.width);
  endfunction

  function automatic int eff_height();
    return (cfg_shadow.height > MAX_HEIGHT) ? MAX_HEIGHT : int'(cfg_shadow.height);
  endfunction

  function automatic int eff_radius();
    return (cfg_shadow.radius > MAX_RADIUS) ? MAX_RADIUS : int'(cfg_shadow.radius);
  endfunction

  // Clamp a window span to [0, lim-1]
  function automatic void clip_span(inout int lo, inout int hi, input int lim);
    if (lo < 0) lo = 0;
    if (hi > lim - 1) hi = lim - 1;
  endfunction

  // Expected reply of one item; updates the shadow maps as the block would
  function automatic pix_res_t predict_pixel_op(pix_req_t q);
    pix_res_t r;
    int px, py, w, h, rad, r2, x0, x1, y0, y1, a, x, y;
    bit in_img, good;
    r.ok = 1'b0;
    r.found = '0;
    r.blocked = '0;
    r.label = LABEL_NONE;
    r.bg = 1'b0;
    r.det = 1'b0;
    px = q.x;
    py = q.y;
    w = eff_width();
    h = eff_height();
    in_img = px >= 0 && px < w && py >= 0 && py < h;
    a = py * MAX_WIDTH + px;
    case (q.kind)
      REQ_LOAD: begin
        if (in_img) begin
          det_map[a] = q.det;
          bg_map[a] = q.bg;
          label_map[a] = LABEL_NONE;
          loaded_map[a] = 1'b1;
        end
      end
      REQ_READ: begin
        if (in_img) begin
          r.label = label_map[a];
          r.bg = bg_map[a];
          r.det = det_map[a];
        end
      end
      REQ_SOURCE: begin
        if (q.idx < MAX_SOURCES) begin
          rad = eff_radius();
          r2 = rad * rad;
          good = q.ok;
          x0 = px - rad;
          x1 = px + rad;
          y0 = py - rad;
          y1 = py + rad;
          // edge rejection uses the unclipped square
          if (cfg_shadow.reject && good && (x0 < 0 || x1 >= w || y0 < 0 || y1 >= h))
            good = 1'b0;
          clip_span(x0, x1, w);
          clip_span(y0, y1, h);
          // detection-mask pass
          if (cfg_shadow.reject && good) begin
            for (y = y0; y <= y1; y++)
              for (x = x0; x <= x1; x++)
                if ((x - px) * (x - px) + (y - py) * (y - py) <= r2 &&
                    !det_map[y * MAX_WIDTH + x])
                  good = 1'b0;
          end
          // blanking pass over unlabelled in-circle pixels
          for (y = y0; y <= y1; y++)
            for (x = x0; x <= x1; x++) begin
              a = y * MAX_WIDTH + x;
              if ((x - px) * (x - px) + (y - py) * (y - py) > r2) continue;
              if (label_map[a] != LABEL_NONE) continue;
              if (good) begin
                label_map[a] = LABEL_W'(q.idx);
                r.found++;
                if (found_total != TOTAL_MAX) found_total++;
              end else begin
                r.blocked++;
              end
              bg_map[a] = 1'b0;
            end
          r.ok = good;
        end
      end
      default: ;
    endcase
    r.total = found_total;
    return r;
  endfunction

  function automatic pix_req_t make_req(logic [REQ_W-1:0] kind, int x, int y, logic det,
                                        logic bg, int idx, logic ok);
    pix_req_t q;
    q.kind = kind;
    q.x = POS_W'(x);
    q.y = POS_W'(y);
    q.det = det;
    q.bg = bg;
    q.idx = IDX_W'(idx);
    q.ok = ok;
    return q;
  endfunction

  // Mostly in-image, some near the edges, a few anywhere in the field
  function automatic logic signed [POS_W-1:0] rand_pos(int lim);
    int sel;
    sel = $urandom_range(0, 9);
    if (lim > 0 && sel < 8) return POS_W'($urandom_range(0, lim - 1));
    if (sel < 9) return POS_W'(int'($urandom_range(0, lim + 5)) - 3);
    return POS_W'($urandom());
  endfunction

  function automatic void check_field(string name, logic signed [17:0] want,
                                      logic signed [17:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
      fails++;
    end
  endfunction

  // Send one request beat; the prediction is taken at acceptance
  task automatic send_item(pix_req_t q);
    int gap;
    gap = tx_idle_en ? $urandom_range(0, 10) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    req_if.valid             <= 1'b1;
    req_if.req_type          <= q.kind;
    req_if.pos_x             <= q.x;
    req_if.pos_y             <= q.y;
    req_if.detect_bit_in     <= q.det;
    req_if.background_bit_in <= q.bg;
    req_if.source_index      <= q.idx;
    req_if.source_ok         <= q.ok;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    pixel_reply_q.push_back(predict_pixel_op(q));
  endtask

  // Drop valid and wait until every reply is in and the block is idle
  task automatic settle();
    @(negedge clk_i);
    req_if.valid <= 1'b0;
    while (pixel_reply_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // APB write, random junk above the register width
  task automatic write_reg(logic [1:0] idx, int unsigned value, int width);
    logic [PDATA_W-1:0] data;
    data = $urandom();
    data = (data << width) | value;
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_RADIUS: cfg_shadow.radius = data[RADIUS_W-1:0];
      REG_REJECT: cfg_shadow.reject = data[0];
      REG_WIDTH:  cfg_shadow.width  = data[SIZE_W-1:0];
      REG_HEIGHT: cfg_shadow.height = data[SIZE_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_config(int unsigned rad, int unsigned rej, int unsigned wid,
                            int unsigned hgt);
    write_reg(REG_RADIUS, rad, RADIUS_W);
    write_reg(REG_REJECT, rej, 1);
    write_reg(REG_WIDTH, wid, SIZE_W);
    write_reg(REG_HEIGHT, hgt, SIZE_W);
  endtask

  // Load an in-image pixel that has never been written, detect bit mostly set
  task automatic ensure_loaded(int x, int y);
    if (x >= 0 && x < eff_width() && y >= 0 && y < eff_height() &&
        !loaded_map[y * MAX_WIDTH + x])
      send_item(make_req(REQ_LOAD, x, y, $urandom_range(0, 7) != 0,
                         1'($urandom_range(0, 1)), $urandom(),
                         1'($urandom_range(0, 1))));
  endtask

  // Every in-image pixel of a source's square window must hold data
  task automatic prep_window(int px, int py);
    int rad, x0, x1, y0, y1, x, y;
    rad = eff_radius();
    x0 = px - rad;
    x1 = px + rad;
    y0 = py - rad;
    y1 = py + rad;
    clip_span(x0, x1, eff_width());
    clip_span(y0, y1, eff_height());
    for (y = y0; y <= y1; y++)
      for (x = x0; x <= x1; x++)
        ensure_loaded(x, y);
  endtask

  task automatic fill_image();
    int x, y;
    for (y = 0; y < eff_height(); y++)
      for (x = 0; x < eff_width(); x++)
        send_item(make_req(REQ_LOAD, x, y, 1'b1, 1'($urandom_range(0, 1)), 0, 1'b0));
  endtask

  // One random item: mostly sources, loads and reads, a little noise
  task automatic random_beat();
    pix_req_t q;
    int sel;
    sel = $urandom_range(0, 99);
    q = make_req(REQ_LOAD, rand_pos(eff_width()), rand_pos(eff_height()),
                 $urandom_range(0, 3) != 0, 1'($urandom_range(0, 1)), $urandom(),
                 $urandom_range(0, 3) != 0);
    if (sel < 45) begin
      q.kind = REQ_SOURCE;
      prep_window(q.x, q.y);
    end else if (sel < 70) begin
      q.kind = REQ_LOAD;
    end else if (sel < 95) begin
      q.kind = REQ_READ;
      ensure_loaded(q.x, q.y);
    end else begin
      q.kind = REQ_UNUSED;
    end
    send_item(q);
  endtask

  task automatic run_random(int count);
    repeat (count) random_beat();
  endtask

  // Loads and reads at the corners, outside the image, unknown request type
  task automatic test_pixel_access();
    send_item(make_req(REQ_LOAD, 0, 0, 1'b1, 1'b1, 0, 1'b0));
    send_item(make_req(REQ_LOAD, 255, 255, 1'b0, 1'b1, 1023, 1'b1));
    send_item(make_req(REQ_LOAD, -64, 319, 1'b1, 1'b1, 0, 1'b0));
    send_item(make_req(REQ_LOAD, 256, 3, 1'b1, 1'b0, 0, 1'b0));
    send_item(make_req(REQ_READ, 0, 0, 1'b0, 1'b0, 0, 1'b0));
    send_item(make_req(REQ_READ, 255, 255, 1'b1, 1'b1, 1023, 1'b1));
    send_item(make_req(REQ_READ, 256, 0, 1'b0, 1'b0, 0, 1'b0));
    send_item(make_req(REQ_READ, -1, 5, 1'b0, 1'b0, 0, 1'b0));
    send_item(make_req(REQ_READ, 0, 319, 1'b0, 1'b0, 0, 1'b0));
    send_item(make_req(REQ_UNUSED, 0, 0, 1'b1, 1'b1, 1023, 1'b1));
  endtask

  // Zero radius: found, already labelled, bad source, window off the image
  task automatic test_source_blank();
    send_item(make_req(REQ_SOURCE, 0, 0, 1'b0, 1'b0, 1023, 1'b1));
    send_item(make_req(REQ_READ, 0, 0, 1'b0, 1'b0, 0, 1'b0));
    send_item(make_req(REQ_SOURCE, 0, 0, 1'b0, 1'b0, 0, 1'b1));
    send_item(make_req(REQ_SOURCE, 255, 255, 1'b0, 1'b0, 5, 1'b0));
    send_item(make_req(REQ_READ, 255, 255, 1'b0, 1'b0, 0, 1'b0));
    send_item(make_req(REQ_SOURCE, -5, -5, 1'b0, 1'b0, 9, 1'b1));
  endtask

  // 3x3 image: good source, edge crossing, masked pixel inside the circle
  task automatic test_border_reject();
    settle();
    set_config(1, 1, 3, 3);
    fill_image();
    send_item(make_req(REQ_SOURCE, 1, 1, 1'b0, 1'b0, 7, 1'b1));
    send_item(make_req(REQ_SOURCE, 0, 1, 1'b0, 1'b0, 8, 1'b1));
    send_item(make_req(REQ_LOAD, 1, 1, 1'b0, 1'b1, 0, 1'b0));
    send_item(make_req(REQ_SOURCE, 1, 1, 1'b0, 1'b0, 9, 1'b1));
  endtask

  // Small image, with a full drain in the middle of the stream
  task automatic test_random_small();
    settle();
    set_config(3, 0, 6, 4);
    run_random(5);
    settle();
    run_random(5);
    settle();
    set_config(2, 1, 6, 4);
    run_random(5);
  endtask

  // Largest and smallest image sizes
  task automatic test_random_full_frame();
    settle();
    set_config(1, 1, 256, 256);
    run_random(4);
    settle();
    set_config(0, 1, 1, 1);
    run_random(3);
  endtask

  // Largest radius on a short wide image
  task automatic test_random_wide_radius();
    settle();
    set_config(31, 0, 10, 3);
    run_random(4);
    settle();
    set_config(31, 1, 10, 3);
    run_random(3);
  endtask

  // Back-to-back beats on both sides
  task automatic test_random_no_idle();
    settle();
    tx_idle_en = 1'b0;
    rx_idle_en = 1'b0;
    set_config(2, 1, 5, 5);
    run_random(6);
    settle();
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  // Empty images and sizes that saturate
  task automatic test_random_odd_sizes();
    settle();
    set_config(4, 0, 511, 0);
    run_random(3);
    settle();
    set_config(4, 1, 0, 511);
    run_random(3);
    settle();
    set_config(1, 0, 511, 20);
    run_random(3);
  endtask

  // Result sink: random stall before each beat, compare with oldest prediction
  initial begin : result_sink
    pix_res_t want;
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_idle_en ? $urandom_range(0, 10) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready <= 1'b1;
      do @(posedge clk_i); while (res_if.valid !== 1'b1);
      if (pixel_reply_q.size() == 0) begin
        $display("%0t: result beat with no item outstanding", $time);
        fails++;
      end else begin
        want = pixel_reply_q.pop_front();
        check_field("status_ok_out", want.ok, res_if.status_ok_out);
        check_field("newly_found", want.found, res_if.newly_found);
        check_field("blocked_pixels", want.blocked, res_if.blocked_pixels);
        check_field("label_out", want.label, res_if.label_out);
        check_field("background_bit_out", want.bg, res_if.background_bit_out);
        check_field("detect_bit_out", want.det, res_if.detect_bit_out);
        check_field("total_found", want.total, res_if.total_found);
      end
    end
  end

  // Watchdog: ends the run after too long without any beat
  initial begin : watchdog
    while (idle_run < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((req_if.valid && req_if.ready) || (res_if.valid && res_if.ready) || psel)
        idle_run = 0;
      else
        idle_run++;
    end
    $display("%0t: watchdog expired after %0d idle cycles", $time, WATCHDOG_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // Main sequence
  initial begin
    rst_ni  = 1'b0;
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = '0;
    pwdata  = '0;
    req_if.valid             = 1'b0;
    req_if.req_type          = '0;
    req_if.pos_x             = '0;
    req_if.pos_y             = '0;
    req_if.detect_bit_in     = 1'b0;
    req_if.background_bit_in = 1'b0;
    req_if.source_index      = '0;
    req_if.source_ok         = 1'b0;
    cfg_shadow = '{radius: '0, reject: 1'b0, width: 9'd256, height: 9'd256};
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;

    test_pixel_access();
    test_source_blank();
    test_border_reject();
    test_random_small();
    test_random_full_frame();
    test_random_wide_radius();
    test_random_no_idle();
    test_random_odd_sizes();
    settle();

    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

FILE: files.f
src/csrb_pkg.sv
src/csrb_req_if.sv
src/csrb_res_if.sv
src/csrb_ram.sv
src/csrb_cfg.sv
src/circular_source_region_blanker_core.sv
tb/tb_top.sv
